[design/pdsd_pkg.sv]
package pdsd_pkg;

   // Field widths
   localparam int KIND_W   = 3;
   localparam int POS_W    = 15;
   localparam int INDEX_W  = 16;
   localparam int SIZE_W   = 8;
   localparam int CHAN_W   = 8;
   localparam int STATUS_W = 3;
   localparam int COLOR_W  = 16;
   localparam int COUNT_W  = 11;

   // Default geometry
   localparam int MAX_WIDTH_DEF     = 35;
   localparam int MAX_HEIGHT_DEF    = 57;
   localparam int PIXEL_DEPTH_DEF   = 2048;
   localparam int PALETTE_DEPTH_DEF = 1024;

   // Request kinds
   localparam logic [KIND_W-1:0] KIND_PALETTE = 3'd0;
   localparam logic [KIND_W-1:0] KIND_FULL    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_DELTA   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_RECORD  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_READ    = 3'd4;

   // Response status codes
   localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_IGNORED   = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_BAD_POS   = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_BAD_INDEX = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_TOO_LARGE = 3'd4;
   localparam logic [STATUS_W-1:0] STAT_MISMATCH  = 3'd5;

   // 8:8:8 to RGB565
   function automatic logic [COLOR_W-1:0] pack565(input logic [CHAN_W-1:0] r,
                                                  input logic [CHAN_W-1:0] g,
                                                  input logic [CHAN_W-1:0] b);
      pack565 = {r[7:3], g[7:2], b[7:3]};
   endfunction

endpackage

[design/pdsd_ifs.sv]
interface pdsd_req_if;
   import pdsd_pkg::*;
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [POS_W-1:0]    position;
   logic                set_pixel;
   logic [INDEX_W-1:0]  color_index;
   logic [SIZE_W-1:0]   width;
   logic [SIZE_W-1:0]   height;
   logic [CHAN_W-1:0]   red;
   logic [CHAN_W-1:0]   green;
   logic [CHAN_W-1:0]   blue;

   modport source (output valid, kind, position, set_pixel, color_index, width, height,
                   red, green, blue, input ready);
   modport sink   (input valid, kind, position, set_pixel, color_index, width, height,
                   red, green, blue, output ready);
endinterface

interface pdsd_rsp_if;
   import pdsd_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic                pixel_opaque;
   logic [COLOR_W-1:0]  pixel_color;

   modport source (output valid, status, pixel_opaque, pixel_color, input ready);
   modport sink   (input valid, status, pixel_opaque, pixel_color, output ready);
endinterface

interface pdsd_csr_if;
   import pdsd_pkg::*;
   logic                valid;
   logic                ready;
   logic [COUNT_W-1:0]  palette_count;

   modport source (output valid, palette_count, input ready);
   modport sink   (input valid, palette_count, output ready);
endinterface

[design/palette_delta_sprite_decoder_top.sv]
// Palette-indexed delta sprite frame decoder.
// req_bus carries one request per handshake: palette write, full frame start,
// delta frame start, pixel record or pixel read. rsp_bus returns exactly one
// response per request (status, plus opaque flag and RGB565 color for reads).
// csr_bus writes palette_count and is always ready; the user writes it only
// while no request is in flight; the block itself does not enforce this.
// At the accept edge the palette and pixel memory reads are issued; the
// execute state, once the response register is free, uses the registered
// read data, writes back and loads the response register, raising rsp valid.
// A new request is not accepted until the previous one has left execute.
// A full frame of legal size starts a sweep that zeroes all PIXEL_DEPTH
// pixel memory entries, one entry per cycle, during which req_ready stays low.
// After reset the same sweep runs before the first request is taken; all
// frame state and palette_count clear to zero.
// A stalled response holds in its register; a new request may still be
// accepted, and it completes as soon as the response register frees up.
module palette_delta_sprite_decoder_top #(
   parameter int MAX_WIDTH     = pdsd_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT    = pdsd_pkg::MAX_HEIGHT_DEF,
   parameter int PIXEL_DEPTH   = pdsd_pkg::PIXEL_DEPTH_DEF,
   parameter int PALETTE_DEPTH = pdsd_pkg::PALETTE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   pdsd_req_if.sink   req_bus,
   pdsd_rsp_if.source rsp_bus,
   pdsd_csr_if.sink   csr_bus
);
   import pdsd_pkg::*;

   localparam int PIX_AW = (PIXEL_DEPTH > 1) ? $clog2(PIXEL_DEPTH) : 1;
   localparam int PAL_AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

   localparam logic [15:0]       PIX_LIM  = 16'(PIXEL_DEPTH);
   localparam logic [16:0]       PAL_LIM  = 17'(PALETTE_DEPTH);
   localparam logic [SIZE_W-1:0] W_LIM    = SIZE_W'(MAX_WIDTH);
   localparam logic [SIZE_W-1:0] H_LIM    = SIZE_W'(MAX_HEIGHT);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   // control
   logic                state_ff, state_in;
   logic                accept;
   logic                out_free;
   logic                exec_go;

   // latched request
   logic [KIND_W-1:0]   kind_ff;
   logic [POS_W-1:0]    pos_ff;
   logic                setp_ff;
   logic [INDEX_W-1:0]  cidx_ff;
   logic [SIZE_W-1:0]   w_ff;
   logic [SIZE_W-1:0]   h_ff;
   logic [COLOR_W-1:0]  rgb_ff;

   // frame state
   logic [SIZE_W-1:0]   cur_w_ff, cur_w_in;
   logic [SIZE_W-1:0]   cur_h_ff, cur_h_in;
   logic [15:0]         area_ff, area_in;
   logic                delta_ff, delta_in;
   logic                failed_ff, failed_in;
   logic [COUNT_W-1:0]  pal_count_ff;

   // response register
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                opq_ff, opq_in;
   logic [COLOR_W-1:0]  col_ff, col_in;

   // memory hookup
   logic                pal_we;
   logic [COLOR_W-1:0]  pal_rd_data;
   logic                clear_start;
   logic                clear_busy;
   logic                pix_we;
   logic                pix_wr_opaque;
   logic                pix_rd_opaque;
   logic [COLOR_W-1:0]  pix_rd_color;

   // range checks
   logic [15:0]         prod;
   logic                pos_bad;
   logic                idx_bad;
   logic                pal_addr_bad;
   logic                too_large;

   assign accept   = req_bus.valid & req_bus.ready;
   assign out_free = ~rsp_valid_ff | rsp_bus.ready;
   assign exec_go  = (state_ff == S_EXEC) & out_free;

   assign req_bus.ready = (state_ff == S_IDLE) & ~clear_busy;
   assign csr_bus.ready = 1'b1;

   // memories
   pdsd_palette_ram #(
      .PALETTE_DEPTH (PALETTE_DEPTH),
      .PAL_AW        (PAL_AW)
   ) u_palette (
      .clock   (clock),
      .wr_en   (pal_we),
      .wr_addr (cidx_ff[PAL_AW-1:0]),
      .wr_data (rgb_ff),
      .rd_en   (accept),
      .rd_addr (req_bus.color_index[PAL_AW-1:0]),
      .rd_data (pal_rd_data)
   );

   pdsd_pixel_ram #(
      .PIXEL_DEPTH (PIXEL_DEPTH),
      .PIX_AW      (PIX_AW)
   ) u_pixel (
      .clock       (clock),
      .reset       (reset),
      .clear_start (clear_start),
      .clear_busy  (clear_busy),
      .wr_en       (pix_we),
      .wr_addr     (pos_ff[PIX_AW-1:0]),
      .wr_opaque   (pix_wr_opaque),
      .wr_color    (pal_rd_data),
      .rd_en       (accept),
      .rd_addr     (req_bus.position[PIX_AW-1:0]),
      .rd_opaque   (pix_rd_opaque),
      .rd_color    (pix_rd_color)
   );

   // request capture
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_bus.kind;
         pos_ff  <= req_bus.position;
         setp_ff <= req_bus.set_pixel;
         cidx_ff <= req_bus.color_index;
         w_ff    <= req_bus.width;
         h_ff    <= req_bus.height;
         rgb_ff  <= pack565(req_bus.red, req_bus.green, req_bus.blue);
      end
   end

   // range checks on the latched request
   assign prod         = 16'(w_ff) * 16'(h_ff);
   assign pos_bad      = ({1'b0, pos_ff} >= area_ff) | ({1'b0, pos_ff} >= PIX_LIM);
   assign pal_addr_bad = {1'b0, cidx_ff} >= PAL_LIM;
   assign idx_bad      = (cidx_ff >= {5'b0, pal_count_ff}) | pal_addr_bad;
   assign too_large    = (w_ff > W_LIM) | (h_ff > H_LIM) | (prod > PIX_LIM);

   // execute: decide status, writes and frame state updates
   always_comb begin
      cur_w_in      = cur_w_ff;
      cur_h_in      = cur_h_ff;
      area_in       = area_ff;
      delta_in      = delta_ff;
      failed_in     = failed_ff;
      status_in     = STAT_OK;
      opq_in        = 1'b0;
      col_in        = '0;
      pal_we        = 1'b0;
      pix_we        = 1'b0;
      pix_wr_opaque = 1'b0;
      clear_start   = 1'b0;
      case (kind_ff)
         KIND_PALETTE: begin
            if (pal_addr_bad) begin
               status_in = STAT_BAD_INDEX;
            end else begin
               pal_we = exec_go;
            end
         end
         KIND_FULL: begin
            if (too_large) begin
               status_in = STAT_TOO_LARGE;
               failed_in = 1'b1;
            end else begin
               cur_w_in    = w_ff;
               cur_h_in    = h_ff;
               area_in     = prod;
               delta_in    = 1'b0;
               failed_in   = 1'b0;
               clear_start = exec_go;
            end
         end
         KIND_DELTA: begin
            if (failed_ff) begin
               status_in = STAT_IGNORED;
            end else if ((w_ff != cur_w_ff) || (h_ff != cur_h_ff)) begin
               status_in = STAT_MISMATCH;
               failed_in = 1'b1;
            end else begin
               delta_in = 1'b1;
            end
         end
         KIND_RECORD: begin
            if (failed_ff) begin
               status_in = STAT_IGNORED;
            end else if (pos_bad) begin
               status_in = STAT_BAD_POS;
               failed_in = 1'b1;
            end else if (delta_ff && !setp_ff) begin
               pix_we        = exec_go;
               pix_wr_opaque = 1'b0;
            end else if (idx_bad) begin
               status_in = STAT_BAD_INDEX;
               failed_in = 1'b1;
            end else begin
               pix_we        = exec_go;
               pix_wr_opaque = 1'b1;
            end
         end
         KIND_READ: begin
            if (pos_bad) begin
               status_in = STAT_BAD_POS;
            end else if (pix_rd_opaque) begin
               opq_in = 1'b1;
               col_in = pix_rd_color;
            end
         end
         default: begin
            status_in = STAT_OK;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_w_ff     <= '0;
         cur_h_ff     <= '0;
         area_ff      <= '0;
         delta_ff     <= 1'b0;
         failed_ff    <= 1'b0;
         pal_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_bus.valid && csr_bus.ready) begin
            pal_count_ff <= csr_bus.palette_count;
         end
         if (exec_go) begin
            cur_w_ff     <= cur_w_in;
            cur_h_ff     <= cur_h_in;
            area_ff      <= area_in;
            delta_ff     <= delta_in;
            failed_ff    <= failed_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (exec_go) begin
         status_ff <= status_in;
         opq_ff    <= opq_in;
         col_ff    <= col_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = status_ff;
   assign rsp_bus.pixel_opaque = opq_ff;
   assign rsp_bus.pixel_color  = col_ff;

endmodule

[design/pdsd_palette_ram.sv]
module pdsd_palette_ram #(
   parameter int PALETTE_DEPTH = pdsd_pkg::PALETTE_DEPTH_DEF,
   parameter int PAL_AW        = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [PAL_AW-1:0]            wr_addr,
   input  logic [pdsd_pkg::COLOR_W-1:0] wr_data,
   input  logic                         rd_en,
   input  logic [PAL_AW-1:0]            rd_addr,
   output logic [pdsd_pkg::COLOR_W-1:0] rd_data
);
   import pdsd_pkg::*;

   logic [COLOR_W-1:0] mem [0:PALETTE_DEPTH-1];
   logic [COLOR_W-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/pdsd_pixel_ram.sv]
module pdsd_pixel_ram #(
   parameter int PIXEL_DEPTH = pdsd_pkg::PIXEL_DEPTH_DEF,
   parameter int PIX_AW      = (PIXEL_DEPTH > 1) ? $clog2(PIXEL_DEPTH) : 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         clear_start,
   output logic                         clear_busy,
   input  logic                         wr_en,
   input  logic [PIX_AW-1:0]            wr_addr,
   input  logic                         wr_opaque,
   input  logic [pdsd_pkg::COLOR_W-1:0] wr_color,
   input  logic                         rd_en,
   input  logic [PIX_AW-1:0]            rd_addr,
   output logic                         rd_opaque,
   output logic [pdsd_pkg::COLOR_W-1:0] rd_color
);
   import pdsd_pkg::*;

   localparam logic [PIX_AW-1:0] LAST_ADDR = PIX_AW'(PIXEL_DEPTH - 1);

   // entry = {opaque, rgb565}
   logic [COLOR_W:0]   mem [0:PIXEL_DEPTH-1];
   logic [COLOR_W:0]   rd_data_ff;
   logic               busy_ff, busy_in;
   logic [PIX_AW-1:0]  cnt_ff, cnt_in;
   logic               mem_we;
   logic [PIX_AW-1:0]  mem_addr;
   logic [COLOR_W:0]   mem_data;

   // clear sweep: one entry per cycle, after reset and on request
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (clear_start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_ADDR) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   // sweep owns the write port while busy
   assign mem_we   = busy_ff | wr_en;
   assign mem_addr = busy_ff ? cnt_ff : wr_addr;
   assign mem_data = busy_ff ? '0 : {wr_opaque, wr_color};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign clear_busy = busy_ff;
   assign rd_opaque  = rd_data_ff[COLOR_W];
   assign rd_color   = rd_data_ff[COLOR_W-1:0];

endmodule
